>>> sv/lsh_pkg.sv
// lsh_pkg: shared constants, types and helpers for the laplacian sharpening filter
// depends on nothing; imported by every module of the filter
package lsh_pkg;

  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned WCFG_W      = 12;
  localparam int unsigned HCFG_W      = 13;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W       = PIX_W + 4;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // output sequencer phases, one per possible result of an item
  typedef enum logic [3:0] {
    PH_MAIN   = 4'b0001,
    PH_RIGHT  = 4'b0010,
    PH_BOTTOM = 4'b0100,
    PH_CORNER = 4'b1000
  } phase_e;

  // frame geometry as last index values plus a restart strobe
  typedef struct packed {
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic             restart;
  } lsh_cfg_t;

  // one classified item: input coordinates, filtered value, border flags
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             last_row;
  } lsh_entry_t;

  // clamp the width register to 3..MAX_WIDTH and return the last column
  function automatic logic [COL_W-1:0] width_last(logic [WCFG_W-1:0] fw);
    logic [COL_W-1:0] res;
    if (fw < WCFG_W'(3)) begin
      res = COL_W'(2);
    end else if (fw > WCFG_W'(MAX_WIDTH)) begin
      res = COL_W'(MAX_WIDTH - 1);
    end else begin
      res = COL_W'(fw - WCFG_W'(1));
    end
    return res;
  endfunction

  // clamp the height register to 3..MAX_HEIGHT and return the last row
  function automatic logic [ROW_W-1:0] height_last(logic [HCFG_W-1:0] fh);
    logic [ROW_W-1:0] res;
    if (fh < HCFG_W'(3)) begin
      res = ROW_W'(2);
    end else if (fh > HCFG_W'(MAX_HEIGHT)) begin
      res = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      res = ROW_W'(fh - HCFG_W'(1));
    end
    return res;
  endfunction

endpackage

>>> sv/lsh_front.sv
// lsh_front: pixel intake, raster counters, two line stores, 3x3 window and kernel
// depends on lsh_pkg; pushes classified items into lsh_queue
module lsh_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lsh_pkg::lsh_cfg_t         cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lsh_pkg::PIX_W-1:0] pixel_i,
  input  logic [lsh_pkg::QCNT_W-1:0] q_count_i,
  output logic                      push_o,
  output lsh_pkg::lsh_entry_t       entry_o
);
  import lsh_pkg::*;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             in_fire;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [PIX_W-1:0] up_rd_q;
  logic [PIX_W-1:0] lo_rd_q;

  logic [PIX_W-1:0] win_q [3][3];

  logic             s2_valid_q;
  logic [COL_W-1:0] s2_col_q;
  logic [ROW_W-1:0] s2_row_q;

  logic [QCNT_W-1:0] in_flight;
  logic [SUM_W-1:0]  centre5;
  logic signed [SUM_W-1:0] kern_sum;
  logic [PIX_W-1:0]  kern_val;
  logic              interior;

  // credit check: room in the queue for everything already in the pipe
  assign in_flight  = q_count_i + QCNT_W'(s1_valid_q) + QCNT_W'(s2_valid_q);
  assign in_ready_o = (in_flight < QCNT_W'(QUEUE_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;

  // raster position of the next pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_i.restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (col_q == cfg_i.w_last) begin
        col_q <= '0;
        row_q <= (row_q == cfg_i.h_last) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // line stores: read on transfer, rotate the column in the cycle after
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      up_rd_q <= upper_mem[col_q];
      lo_rd_q <= lower_mem[col_q];
    end
    if (s1_valid_q) begin
      upper_mem[s1_col_q] <= lo_rd_q;
      lower_mem[s1_col_q] <= s1_pix_q;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= pixel_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // window shift with the freshly read column
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= up_rd_q;
      win_q[1][2] <= lo_rd_q;
      win_q[2][2] <= s1_pix_q;
    end
  end

  // stage two coordinates
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
    end
  end

  // stage valids; only items that give a result go on to stage two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q && (s1_col_q != '0) && (s1_row_q != '0);
    end
  end

  // kernel: 5*centre minus the four direct neighbours, clamped
  assign centre5  = {2'b00, win_q[1][1], 2'b00} + {4'h0, win_q[1][1]};
  assign kern_sum = $signed(centre5)
                  - $signed({4'h0, win_q[1][0]}) - $signed({4'h0, win_q[1][2]})
                  - $signed({4'h0, win_q[0][1]}) - $signed({4'h0, win_q[2][1]});

  always_comb begin
    if (kern_sum < 0) begin
      kern_val = '0;
    end else if (kern_sum > $signed(SUM_W'(255))) begin
      kern_val = '1;
    end else begin
      kern_val = kern_sum[PIX_W-1:0];
    end
  end

  assign interior = (s2_col_q >= COL_W'(2)) && (s2_row_q >= ROW_W'(2));

  // classified item towards the queue
  assign push_o            = s2_valid_q;
  assign entry_o.value     = interior ? kern_val : '0;
  assign entry_o.row       = s2_row_q;
  assign entry_o.col       = s2_col_q;
  assign entry_o.last_col  = (s2_col_q == cfg_i.w_last);
  assign entry_o.last_row  = (s2_row_q == cfg_i.h_last);

endmodule

>>> sv/lsh_queue.sv
// lsh_queue: short register queue between the front and the output sequencer
// depends on lsh_pkg
module lsh_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  lsh_pkg::lsh_entry_t        entry_i,
  input  logic                       pop_i,
  output lsh_pkg::lsh_entry_t        head_o,
  output logic [lsh_pkg::QCNT_W-1:0] count_o
);
  import lsh_pkg::*;

  lsh_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

>>> sv/lsh_back.sv
// lsh_back: output sequencer expanding each queued item into its one to four results
// depends on lsh_pkg; reads the head of lsh_queue
module lsh_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lsh_pkg::lsh_entry_t        head_i,
  input  logic                       head_valid_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lsh_pkg::PIX_W-1:0]  value_o,
  output logic [lsh_pkg::ROW_W-1:0]  out_row_o,
  output logic [lsh_pkg::COL_W-1:0]  out_col_o,
  output logic                       run_last_o,
  output logic                       frame_end_o
);
  import lsh_pkg::*;

  phase_e phase_q;
  phase_e phase_d;
  logic   out_fire;
  logic   done;

  assign out_valid_o = head_valid_i;
  assign out_fire    = head_valid_i && out_ready_i;

  // next phase and end of run for the current item
  always_comb begin
    phase_d = phase_q;
    done    = 1'b1;
    case (phase_q)
      PH_MAIN: begin
        if (head_i.last_col) begin
          phase_d = PH_RIGHT;
          done    = 1'b0;
        end else if (head_i.last_row) begin
          phase_d = PH_BOTTOM;
          done    = 1'b0;
        end
      end
      PH_RIGHT: begin
        if (head_i.last_row) begin
          phase_d = PH_BOTTOM;
          done    = 1'b0;
        end
      end
      PH_BOTTOM: begin
        if (head_i.last_col) begin
          phase_d = PH_CORNER;
          done    = 1'b0;
        end
      end
      PH_CORNER: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (done) begin
      phase_d = PH_MAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAIN;
    end else if (out_fire) begin
      phase_q <= phase_d;
    end
  end

  assign pop_o = out_fire && done;

  // result fields per phase
  always_comb begin
    value_o     = '0;
    out_row_o   = head_i.row - ROW_W'(1);
    out_col_o   = head_i.col - COL_W'(1);
    frame_end_o = 1'b0;
    case (phase_q)
      PH_MAIN: begin
        value_o = head_i.value;
      end
      PH_RIGHT: begin
        out_col_o = head_i.col;
      end
      PH_BOTTOM: begin
        out_row_o = head_i.row;
      end
      PH_CORNER: begin
        out_row_o   = head_i.row;
        out_col_o   = head_i.col;
        frame_end_o = 1'b1;
      end
      default: begin
        value_o = '0;
      end
    endcase
  end

  assign run_last_o = done;

endmodule

>>> sv/laplacian_sharpen_3x3.sv
// laplacian_sharpen_3x3: top level of the streaming 3x3 laplacian sharpening filter
// depends on lsh_pkg, lsh_front, lsh_queue and lsh_back
//
// Takes one 8-bit pixel per transfer in raster order and returns 5*centre minus
// the four direct neighbours, clamped to 0..255, with zero on the frame border.
// A pixel at row r, column c completes the result for (r-1, c-1); at the last
// column it also gives (r-1, last column), and in the last row the bottom-row
// zeros, so one pixel gives up to four results, each with its coordinates,
// run_last on the final one and frame_end on the bottom-right pixel. Pixels on
// row 0 or column 0 give none. Rate: one pixel per clock while the queue has
// room, set by the one read and one write per cycle of each line store; the
// output sequencer sends a pixel's results one per cycle unless stalled, and a
// four-entry queue lets the intake run on while the output is stalled, until
// it fills. Results pass stage one, stage two and the queue. No clearing pass
// after reset. Writing frame_width or frame_height (clamped to 3..2048 and
// 3..4096) restarts the frame; write only while the filter is idle.
module laplacian_sharpen_3x3 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [lsh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lsh_pkg::PIX_W-1:0]      pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lsh_pkg::PIX_W-1:0]      value_o,
  output logic [lsh_pkg::ROW_W-1:0]      out_row_o,
  output logic [lsh_pkg::COL_W-1:0]      out_col_o,
  output logic                           run_last_o,
  output logic                           frame_end_o
);
  import lsh_pkg::*;

  logic [COL_W-1:0]  w_last_q;
  logic [ROW_W-1:0]  h_last_q;
  lsh_cfg_t          cfg;
  logic              push;
  lsh_entry_t        push_entry;
  logic              pop;
  lsh_entry_t        head;
  logic [QCNT_W-1:0] q_count;

  // geometry registers, stored clamped as last indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= COL_W'(639);
      h_last_q <= ROW_W'(479);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  w_last_q <= width_last(cfg_wdata_i[WCFG_W-1:0]);
        REG_FRAME_HEIGHT: h_last_q <= height_last(cfg_wdata_i[HCFG_W-1:0]);
        default:          w_last_q <= w_last_q;
      endcase
    end
  end

  assign cfg.w_last  = w_last_q;
  assign cfg.h_last  = h_last_q;
  assign cfg.restart = cfg_we_i;

  lsh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  lsh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  lsh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_count != '0),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o)
  );

  // credit scheme must never overfill the queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue overflow");

  // nothing leaves an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != '0))
    else $error("queue underflow");

  // the corner result closes its run and is a border zero
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (run_last_o && (value_o == '0)))
    else $error("frame end result malformed");

endmodule
